@@ rtl/sbs_pkg.sv @@
// Shared types and constants for the sparse binomial sampler.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package sbs_pkg;

  // Decoding selected by the mode register
  typedef enum logic [1:0] {
    MODE_SPARSE3  = 2'd0,
    MODE_BINOM    = 2'd1,
    MODE_SPARSE4  = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  // Ternary coefficient in two's complement
  typedef logic signed [1:0] coef_t;

  localparam coef_t COEF_ZERO = 2'sb00;
  localparam coef_t COEF_POS  = 2'sb01;
  localparam coef_t COEF_NEG  = 2'sb11;

  localparam int unsigned RUN_MAX = 16;
  localparam int unsigned POS_W   = 4;

  // One decoded chunk, waiting to be played out coefficient by coefficient
  typedef struct packed {
    logic [RUN_MAX-1:0][1:0] coefs;
    logic                    long_run;  // 16 coefficients, else 8
  } chunk_entry_t;

endpackage

@@ rtl/sbs_front.sv @@
// Front end: holds the mode register, gathers bytes into chunks and
// decodes each complete chunk into a run of ternary coefficients.
// Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           random_byte,
  output logic                 q_wr,
  output sbs_pkg::chunk_entry_t q_data,
  input  logic                 q_full
);

  localparam int unsigned RUN_LEN = sbs_pkg::RUN_MAX;

  sbs_pkg::mode_t mode;
  logic [23:0]    chunk_bytes;
  logic [1:0]     byte_count;
  logic           take;
  logic           complete;
  logic [31:0]    t;
  logic [RUN_LEN-1:0][1:0] sp3, bin, sp4;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign take      = push && !q_full;

  // A byte completes the chunk depending on the mode in force on arrival
  always_comb begin
    if (mode == sbs_pkg::MODE_SPARSE3) begin
      complete = (byte_count >= 2'd2);
      t        = {8'h00, random_byte, chunk_bytes[15:0]};
    end else begin
      complete = (byte_count == 2'd3);
      t        = {random_byte, chunk_bytes};
    end
  end

  // Decode all three schemes side by side
  always_comb begin
    sp3 = '0;
    sp4 = '0;
    for (int j = 0; j < 8; j++) begin
      if (t[3*j] && t[3*j+1]) begin
        sp3[j] = t[3*j+2] ? sbs_pkg::COEF_NEG : sbs_pkg::COEF_POS;
      end
      if ((t[4*j] || t[4*j+1]) && t[4*j+2]) begin
        sp4[j] = t[4*j+3] ? sbs_pkg::COEF_NEG : sbs_pkg::COEF_POS;
      end
    end
    for (int j = 0; j < 16; j++) begin
      if (t[2*j] == t[2*j+1]) begin
        bin[j] = sbs_pkg::COEF_ZERO;
      end else begin
        bin[j] = t[2*j] ? sbs_pkg::COEF_POS : sbs_pkg::COEF_NEG;
      end
    end
  end

  // Select the run for the current mode
  always_comb begin
    case (mode) inside
      sbs_pkg::MODE_SPARSE3: begin
        q_data.coefs    = sp3;
        q_data.long_run = 1'b0;
      end
      sbs_pkg::MODE_SPARSE4: begin
        q_data.coefs    = sp4;
        q_data.long_run = 1'b0;
      end
      sbs_pkg::MODE_BINOM, sbs_pkg::MODE_RESERVED: begin
        q_data.coefs    = bin;
        q_data.long_run = 1'b1;
      end
      default: begin
        q_data.coefs    = bin;
        q_data.long_run = 1'b1;
      end
    endcase
  end

  assign q_wr = take && complete;

  // Mode register and chunk gathering
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sbs_pkg::MODE_SPARSE3;
      chunk_bytes <= '0;
      byte_count  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= sbs_pkg::mode_t'(cfg_data);
      end
      if (take) begin
        if (complete) begin
          chunk_bytes <= '0;
          byte_count  <= '0;
        end else begin
          case (byte_count)
            2'd0:    chunk_bytes[7:0]   <= chunk_bytes[7:0]   | random_byte;
            2'd1:    chunk_bytes[15:8]  <= chunk_bytes[15:8]  | random_byte;
            default: chunk_bytes[23:16] <= chunk_bytes[23:16] | random_byte;
          endcase
          byte_count <= byte_count + 2'd1;
        end
      end
    end
  end

endmodule

@@ rtl/sbs_chunk_queue.sv @@
// Two-entry queue of decoded chunks between the front and back ends.
// Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_chunk_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  sbs_pkg::chunk_entry_t wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output sbs_pkg::chunk_entry_t rd_data,
  output logic                  empty
);

  sbs_pkg::chunk_entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/sbs_back.sv @@
// Back end: plays out a decoded chunk one coefficient per cycle unless pop
// stalls, numbers each one and registers it at the output. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_back #(
  parameter int unsigned POLY_DEGREE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  sbs_pkg::chunk_entry_t q_data,
  output logic                  q_rd,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [1:0]     coefficient,
  output logic [7:0]            coeff_index,
  output logic                  run_last,
  output logic                  poly_last
);

  localparam int unsigned IDX_W =
    (POLY_DEGREE > 256) ? $clog2(POLY_DEGREE) : 8;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(POLY_DEGREE - 1);

  logic                          out_valid;
  logic                          busy;
  sbs_pkg::chunk_entry_t         cur;
  logic [sbs_pkg::POS_W-1:0]     pos;
  logic [sbs_pkg::POS_W-1:0]     last_pos;
  logic [IDX_W-1:0]              next_index;
  logic                          advance;
  logic                          emit;
  logic                          finishing;
  logic                          load;
  logic                          at_top;

  assign last_pos  = cur.long_run ? sbs_pkg::POS_W'(sbs_pkg::RUN_MAX - 1)
                                  : sbs_pkg::POS_W'(sbs_pkg::RUN_MAX / 2 - 1);
  assign advance   = !out_valid || pop;
  assign emit      = busy && advance;
  assign finishing = emit && (pos == last_pos);
  assign load      = (!busy || finishing) && !q_empty;
  assign q_rd      = load;
  assign at_top    = (next_index == IDX_TOP);
  assign empty     = !out_valid;

  // Run control, index counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      next_index <= '0;
      pos        <= '0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        next_index <= at_top ? '0 : next_index + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (finishing) begin
        busy <= 1'b0;
      end else if (emit) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Chunk hold and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
    if (emit) begin
      coefficient <= cur.coefs[pos];
      coeff_index <= next_index[7:0];
      run_last    <= (pos == last_pos);
      poly_last   <= at_top;
    end
  end

endmodule

@@ rtl/sparse_binomial_sampler_unit.sv @@
// Top level of the sparse binomial sampler: front end, chunk queue and
// back end. Depends on sbs_pkg, sbs_front, sbs_chunk_queue, sbs_back.
//
//  Channel   Handshake                 Payload
//  -------   ------------------------  ---------------------------------------
//  config    cfg_valid / cfg_ready     cfg_data (mode)
//  input     push / full               random_byte
//  result    empty / pop               coefficient, coeff_index, run_last,
//                                      poly_last
//
// A byte is taken when push is high and full is low; a byte that completes
// a chunk yields 8 or 16 coefficients, one per cycle from the back end
// unless a stalled pop holds them. Reset (rst, synchronous) clears the mode,
// the chunk and the index. full rises while the two-entry chunk queue is
// full; a stalled pop holds the result and the back end in place.
`timescale 1ns / 1ps

module sparse_binomial_sampler_unit #(
  parameter int unsigned POLY_DEGREE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        random_byte,
  output logic              empty,
  input  logic              pop,
  output logic signed [1:0] coefficient,
  output logic [7:0]        coeff_index,
  output logic              run_last,
  output logic              poly_last
);

  logic                  q_wr;
  logic                  q_full;
  logic                  q_rd;
  logic                  q_empty;
  sbs_pkg::chunk_entry_t q_wr_data;
  sbs_pkg::chunk_entry_t q_rd_data;

  sbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .random_byte (random_byte),
    .q_wr        (q_wr),
    .q_data      (q_wr_data),
    .q_full      (q_full)
  );

  sbs_chunk_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  sbs_back #(
    .POLY_DEGREE (POLY_DEGREE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .coefficient (coefficient),
    .coeff_index (coeff_index),
    .run_last    (run_last),
    .poly_last   (poly_last)
  );

  // A shown coefficient is always a legal ternary value
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (coefficient != 2'sb10))
    else $error("illegal coefficient code");

  // The polynomial closes only on its top index
  assert property (@(posedge clk) disable iff (rst)
    (!empty && poly_last) |-> (coeff_index == 8'(POLY_DEGREE - 1)))
    else $error("poly_last on wrong index");

  // Nothing reaches the output without a queued chunk behind it
  assert property (@(posedge clk) disable iff (rst)
    (empty && q_empty && !q_wr) |=> (empty || $past(u_back.busy)))
    else $error("result appeared with no chunk");

  // Output is empty right after reset
  assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("output not empty after reset");

endmodule

@@ bench/tb_sparse_binomial_sampler_unit.sv @@
// Self-checking bench for sparse_binomial_sampler_unit: directed chunks per mode, then random
// bytes under shifting push/pop back-pressure, checked against an in-bench decoder.
// Depends on sbs_pkg and the sampler RTL only.
`timescale 1ns / 1ps

module tb_sparse_binomial_sampler_unit;

  localparam int unsigned DEGREE     = 256;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PAUSE = 8;

  typedef struct {
    sbs_pkg::coef_t coef;
    logic [7:0]     idx;
    logic           run_end;
    logic           poly_end;
  } coef_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_data = 2'd0;
  logic              push = 1'b0;
  logic              full;
  logic [7:0]        random_byte = 8'd0;
  logic              empty;
  logic              pop = 1'b0;
  logic signed [1:0] coefficient;
  logic [7:0]        coeff_index;
  logic              run_last;
  logic              poly_last;

  // Decoder state mirrored in the bench
  sbs_pkg::mode_t cur_mode = sbs_pkg::MODE_SPARSE3;
  logic [23:0] held_bytes = '0;
  int unsigned held_count = 0;
  int unsigned next_pos = 0;

  coef_result_t pending_coefs[$];
  int unsigned  mismatch_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  quiet_cycles = 0;

  sparse_binomial_sampler_unit #(
    .POLY_DEGREE(DEGREE)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .random_byte(random_byte),
    .empty      (empty),
    .pop        (pop),
    .coefficient(coefficient),
    .coeff_index(coeff_index),
    .run_last   (run_last),
    .poly_last  (poly_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sbs_pkg::coef_t ternary(input logic nz, input logic neg);
    if (!nz) return sbs_pkg::COEF_ZERO;
    return neg ? sbs_pkg::COEF_NEG : sbs_pkg::COEF_POS;
  endfunction

  task automatic queue_coef(input sbs_pkg::coef_t c, input logic run_end);
    coef_result_t r;
    r.coef     = c;
    r.idx      = next_pos[7:0];
    r.run_end  = run_end;
    r.poly_end = (next_pos == DEGREE - 1);
    pending_coefs.push_back(r);
    next_pos = (next_pos + 1) % DEGREE;
  endtask

  // Gather one byte; on a complete chunk queue its coefficients
  task automatic predict_coefficients(input logic [7:0] value);
    logic [31:0] t;
    int unsigned need;
    need = (cur_mode == sbs_pkg::MODE_SPARSE3) ? 2 : 3;
    if (held_count < need) begin
      held_bytes[8*held_count +: 8] = value;
      held_count++;
    end else begin
      if (cur_mode == sbs_pkg::MODE_SPARSE3) begin
        // third held byte, if any, is dropped here
        t = {8'h00, value, held_bytes[15:0]};
        for (int j = 0; j < 8; j++)
          queue_coef(ternary(t[3*j] & t[3*j+1], t[3*j+2]), j == 7);
      end else if (cur_mode == sbs_pkg::MODE_SPARSE4) begin
        t = {value, held_bytes};
        for (int j = 0; j < 8; j++)
          queue_coef(ternary((t[4*j] | t[4*j+1]) & t[4*j+2], t[4*j+3]), j == 7);
      end else begin
        // plain binomial, reserved mode included
        t = {value, held_bytes};
        for (int j = 0; j < 16; j++)
          queue_coef(ternary(t[2*j] ^ t[2*j+1], t[2*j+1]), j == 15);
      end
      held_bytes = '0;
      held_count = 0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one byte, with random gaps, and hold it until the transfer
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    random_byte <= value;
    do @(posedge clk); while (full);
    predict_coefficients(value);
  endtask

  task automatic send_bytes(input logic [7:0] values[]);
    foreach (values[i]) send_byte(values[i]);
  endtask

  // Drain all results, let in-flight bytes settle, then write the mode
  task automatic set_mode(input sbs_pkg::mode_t m);
    push <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    cfg_valid <= 1'b0;
  endtask

  // Mode 0 straight out of reset: all -1, then all +1
  task automatic test_sparse3_from_reset();
    send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hDB, 8'hB6, 8'h6D});
  endtask

  // One chunk covering +1, -1 and both zero pairs
  task automatic test_binomial_mode();
    set_mode(sbs_pkg::MODE_BINOM);
    send_bytes('{8'h55, 8'hAA, 8'h00, 8'hFF});
  endtask

  task automatic test_sparse4_mode();
    set_mode(sbs_pkg::MODE_SPARSE4);
    send_bytes('{8'h77, 8'hFF, 8'h08, 8'h00});
  endtask

  // Reserved mode must decode as the binomial mode
  task automatic test_reserved_mode();
    set_mode(sbs_pkg::MODE_RESERVED);
    send_bytes('{8'h1B, 8'hE4, 8'h6C, 8'h93});
  endtask

  // Switch with a partial chunk held, both directions
  task automatic test_mode_switch_mid_chunk();
    set_mode(sbs_pkg::MODE_BINOM);
    send_bytes('{8'h3C, 8'hC3, 8'h5A});
    set_mode(sbs_pkg::MODE_SPARSE3);
    send_byte(8'hA5);
    send_bytes('{8'h96, 8'h69});
    set_mode(sbs_pkg::MODE_SPARSE4);
    send_bytes('{8'hF0, 8'h0F});
  endtask

  // Random modes and bytes, mostly whole chunks, under three idling regimes
  task automatic test_random_traffic();
    int unsigned send_pct[3] = '{11, 81, 0};
    int unsigned recv_pct[3] = '{81, 11, 0};
    int unsigned left;
    int unsigned n;
    sbs_pkg::mode_t m;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      left = 78;
      while (left > 0) begin
        m = sbs_pkg::mode_t'(2'($urandom_range(3)));
        set_mode(m);
        n = ((m == sbs_pkg::MODE_SPARSE3) ? 3 : 4) * $urandom_range(1, 6);
        if ($urandom_range(3) == 0) n += $urandom_range(1, 3);
        if (n > left) n = left;
        repeat (n) send_byte(8'($urandom_range(255)));
        left -= n;
      end
    end
  endtask

  // Receiver: random pop according to the current idling rate
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each popped coefficient with the oldest prediction
  always @(posedge clk) begin : check_results
    coef_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_coefs.size() == 0) begin
        flag_mismatch($sformatf("unexpected result index %0d", coeff_index));
      end else begin
        want = pending_coefs.pop_front();
        if (coefficient !== want.coef)
          flag_mismatch($sformatf("coefficient %0d, want %0d at index %0d",
                                  coefficient, want.coef, want.idx));
        if (coeff_index !== want.idx)
          flag_mismatch($sformatf("coeff_index %0d, want %0d", coeff_index, want.idx));
        if (run_last !== want.run_end)
          flag_mismatch($sformatf("run_last %b, want %b at index %0d",
                                  run_last, want.run_end, want.idx));
        if (poly_last !== want.poly_end)
          flag_mismatch($sformatf("poly_last %b, want %b at index %0d",
                                  poly_last, want.poly_end, want.idx));
      end
    end
  end

  // Abort if no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 81;

    test_sparse3_from_reset();
    test_binomial_mode();
    test_sparse4_mode();
    test_reserved_mode();
    test_mode_switch_mid_chunk();
    test_random_traffic();

    // Drain and let the pipeline go quiet
    push <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
